### rtl/mi26_pkg.sv
`default_nettype none

package mi26_pkg;

	localparam int unsigned Modulus    = 26;
	// floor(v * RecipMul / 2^RecipShift) is floor(v / 26) or one less for v below 2048
	localparam int unsigned RecipMul   = 315;
	localparam int unsigned RecipShift = 13;

	typedef logic [4:0]      res_t;
	typedef logic [9:0]      prod_t;
	typedef logic [10:0]     wide_t;
	typedef res_t [2:0]      row_t;
	typedef row_t [2:0]      mat_t;
	typedef prod_t [1:0]     pair_t;
	typedef pair_t [8:0]     pairs_t;
	typedef prod_t [2:0][2:0] pmat_t;

	typedef struct packed {
		logic found;
		res_t inv;
	} inv_t;

	// residue of a value below 2048
	function automatic res_t mod26(input wide_t v);
		logic [19:0] prod;
		logic [6:0]  q;
		wide_t       r;
		prod = 20'(v) * 20'(RecipMul);
		q    = 7'(prod >> RecipShift);
		r    = v - 11'(q) * 11'(Modulus);
		if (r >= 11'(Modulus)) begin
			r = r - 11'(Modulus);
		end
		return r[4:0];
	endfunction

	function automatic prod_t mul5(input res_t a, input res_t b);
		return prod_t'(a) * prod_t'(b);
	endfunction

	// (a - b) mod 26 with both operands already reduced
	function automatic res_t sub26(input res_t a, input res_t b);
		logic [5:0] d;
		d = 6'(a) + 6'(Modulus) - 6'(b);
		if (d >= 6'(Modulus)) begin
			d = d - 6'(Modulus);
		end
		return d[4:0];
	endfunction

	// multiplicative inverse mod 26, found clear for non-units
	function automatic inv_t inv26(input res_t d);
		inv_t t;
		t.found = 1'b1;
		unique case (d)
			5'd1:    t.inv = 5'd1;
			5'd3:    t.inv = 5'd9;
			5'd5:    t.inv = 5'd21;
			5'd7:    t.inv = 5'd15;
			5'd9:    t.inv = 5'd3;
			5'd11:   t.inv = 5'd19;
			5'd15:   t.inv = 5'd7;
			5'd17:   t.inv = 5'd23;
			5'd19:   t.inv = 5'd11;
			5'd21:   t.inv = 5'd5;
			5'd23:   t.inv = 5'd17;
			5'd25:   t.inv = 5'd25;
			default: begin
				t.found = 1'b0;
				t.inv   = 5'd0;
			end
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

### rtl/mi26_adj.sv
`default_nettype none

module mi26_adj
	import mi26_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  en,
	input  wire  in_vld,
	input  mat_t in_mat,
	output logic out_vld,
	output mat_t out_adj,
	output row_t out_row0
);

	mat_t   m;
	pairs_t p;
	pairs_t p_s1;
	res_t [8:0][1:0] r_s2;
	row_t   row0_s1;
	row_t   row0_s2;
	row_t   row0_s3;
	mat_t   adj_s3;
	logic   v_s1;
	logic   v_s2;
	logic   v_s3;

	// stage 1: input reduction and the eighteen cofactor products
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				m[r][c] = mod26(wide_t'(in_mat[r][c]));
			end
		end
		p[0] = {mul5(m[2][1], m[1][2]), mul5(m[1][1], m[2][2])};
		p[1] = {mul5(m[0][1], m[2][2]), mul5(m[0][2], m[2][1])};
		p[2] = {mul5(m[0][2], m[1][1]), mul5(m[0][1], m[1][2])};
		p[3] = {mul5(m[1][0], m[2][2]), mul5(m[1][2], m[2][0])};
		p[4] = {mul5(m[0][2], m[2][0]), mul5(m[0][0], m[2][2])};
		p[5] = {mul5(m[0][0], m[1][2]), mul5(m[1][0], m[0][2])};
		p[6] = {mul5(m[2][0], m[1][1]), mul5(m[1][0], m[2][1])};
		p[7] = {mul5(m[0][0], m[2][1]), mul5(m[2][0], m[0][1])};
		p[8] = {mul5(m[1][0], m[0][1]), mul5(m[0][0], m[1][1])};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= p;
			row0_s1 <= m[0];
			// stage 2: reduce products
			for (int k = 0; k < 9; k++) begin
				for (int j = 0; j < 2; j++) begin
					r_s2[k][j] <= mod26(wide_t'(p_s1[k][j]));
				end
			end
			row0_s2 <= row0_s1;
			// stage 3: cofactor differences
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					adj_s3[r][c] <= sub26(r_s2[r * 3 + c][0], r_s2[r * 3 + c][1]);
				end
			end
			row0_s3 <= row0_s2;
		end
	end

	assign out_vld  = v_s3;
	assign out_adj  = adj_s3;
	assign out_row0 = row0_s3;

endmodule

`default_nettype wire

### rtl/mi26_det.sv
`default_nettype none

module mi26_det
	import mi26_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  en,
	input  wire  in_vld,
	input  mat_t in_adj,
	input  row_t in_row0,
	output logic out_vld,
	output mat_t out_adj,
	output res_t out_det,
	output inv_t out_inv
);

	wide_t sum_s4;
	mat_t  adj_s4;
	mat_t  adj_s5;
	res_t  det;
	res_t  det_s5;
	inv_t  inv_s5;
	logic  v_s4;
	logic  v_s5;

	assign det = mod26(sum_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= in_vld;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 4: expansion along row 0
			sum_s4 <= wide_t'(mul5(in_row0[0], in_adj[0][0]))
				+ wide_t'(mul5(in_row0[1], in_adj[1][0]))
				+ wide_t'(mul5(in_row0[2], in_adj[2][0]));
			adj_s4 <= in_adj;
			// stage 5: reduce and look up the inverse
			det_s5 <= det;
			inv_s5 <= inv26(det);
			adj_s5 <= adj_s4;
		end
	end

	assign out_vld = v_s5;
	assign out_adj = adj_s5;
	assign out_det = det_s5;
	assign out_inv = inv_s5;

	a_inv_is_unit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && inv_s5.found |-> mod26(wide_t'(mul5(det_s5, inv_s5.inv))) == 5'd1)
		else $error("determinant inverse check failed");

	a_nonunit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !inv_s5.found |-> det_s5[0] == 1'b0 || det_s5 == 5'd13)
		else $error("unit determinant flagged without inverse");

endmodule

`default_nettype wire

### rtl/mi26_scale.sv
`default_nettype none

module mi26_scale
	import mi26_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  en,
	input  wire  in_vld,
	input  mat_t in_adj,
	input  res_t in_det,
	input  inv_t in_inv,
	output logic out_vld,
	output mat_t out_mat,
	output logic out_sing,
	output res_t out_det
);

	pmat_t prod_s6;
	logic  found_s6;
	res_t  det_s6;
	mat_t  mat_s7;
	logic  sing_s7;
	res_t  det_s7;
	logic  v_s6;
	logic  v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= in_vld;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 6: scale adjugate by det inverse
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s6[r][c] <= mul5(in_adj[r][c], in_inv.inv);
				end
			end
			found_s6 <= in_inv.found;
			det_s6   <= in_det;
			// stage 7: reduce, zero when singular
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					mat_s7[r][c] <= found_s6 ? mod26(wide_t'(prod_s6[r][c])) : 5'd0;
				end
			end
			sing_s7 <= !found_s6;
			det_s7  <= det_s6;
		end
	end

	assign out_vld  = v_s7;
	assign out_mat  = mat_s7;
	assign out_sing = sing_s7;
	assign out_det  = det_s7;

endmodule

`default_nettype wire

### rtl/matrix_inverse_3x3_mod26.sv
// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------------------
// request   | in_valid / in_ready   | in_r0c0 .. in_r2c2 (5 bit residues)
// result    | out_valid / out_ready | out_r0c0 .. out_r2c2, singular, determinant
//
// seven register stages, one request per cycle while the output is not stalled
// stages: reduce+products, reduce, cofactor, det sum, det reduce+inverse,
//   scale products, reduce+zero
// the whole pipe advances together; in_ready = !out_valid || out_ready
// a stall at the output freezes every stage, nothing dropped or repeated
// arst_n clears the stage valid bits only; data registers are not reset
`default_nettype none

module matrix_inverse_3x3_mod26
	import mi26_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [4:0] in_r0c0,
	input  wire  [4:0] in_r0c1,
	input  wire  [4:0] in_r0c2,
	input  wire  [4:0] in_r1c0,
	input  wire  [4:0] in_r1c1,
	input  wire  [4:0] in_r1c2,
	input  wire  [4:0] in_r2c0,
	input  wire  [4:0] in_r2c1,
	input  wire  [4:0] in_r2c2,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [4:0] out_r0c0,
	output logic [4:0] out_r0c1,
	output logic [4:0] out_r0c2,
	output logic [4:0] out_r1c0,
	output logic [4:0] out_r1c1,
	output logic [4:0] out_r1c2,
	output logic [4:0] out_r2c0,
	output logic [4:0] out_r2c1,
	output logic [4:0] out_r2c2,
	output logic       singular,
	output logic [4:0] determinant
);

	// global pipeline advance
	logic en;
	mat_t in_mat;
	logic adj_vld;
	mat_t adj;
	row_t row0;
	logic det_vld;
	mat_t adj_d;
	res_t det;
	inv_t inv;
	mat_t res_mat;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	assign in_mat[0] = {in_r0c2, in_r0c1, in_r0c0};
	assign in_mat[1] = {in_r1c2, in_r1c1, in_r1c0};
	assign in_mat[2] = {in_r2c2, in_r2c1, in_r2c0};

	// stages 1..3: adjugate
	mi26_adj u_adj (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid),
		.in_mat   (in_mat),
		.out_vld  (adj_vld),
		.out_adj  (adj),
		.out_row0 (row0)
	);

	// stages 4..5: determinant and its inverse
	mi26_det u_det (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (adj_vld),
		.in_adj  (adj),
		.in_row0 (row0),
		.out_vld (det_vld),
		.out_adj (adj_d),
		.out_det (det),
		.out_inv (inv)
	);

	// stages 6..7: scaling and output register
	mi26_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (det_vld),
		.in_adj   (adj_d),
		.in_det   (det),
		.in_inv   (inv),
		.out_vld  (out_valid),
		.out_mat  (res_mat),
		.out_sing (singular),
		.out_det  (determinant)
	);

	assign out_r0c0 = res_mat[0][0];
	assign out_r0c1 = res_mat[0][1];
	assign out_r0c2 = res_mat[0][2];
	assign out_r1c0 = res_mat[1][0];
	assign out_r1c1 = res_mat[1][1];
	assign out_r1c2 = res_mat[1][2];
	assign out_r2c0 = res_mat[2][0];
	assign out_r2c1 = res_mat[2][1];
	assign out_r2c2 = res_mat[2][2];

	// a singular result carries an all-zero matrix
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> res_mat == '0)
		else $error("singular result with nonzero entries");

	// an invertible determinant is odd and not 13
	a_unit_det: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !singular |-> determinant[0] == 1'b1 && determinant != 5'd13)
		else $error("non-unit determinant marked invertible");

	// the determinant and the diagonal and corner result residues stay below the modulus
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> determinant < 5'd26 && out_r0c0 < 5'd26 && out_r1c1 < 5'd26
			&& out_r2c2 < 5'd26 && out_r0c2 < 5'd26 && out_r2c0 < 5'd26)
		else $error("result residue out of range");

endmodule

`default_nettype wire

### tb/sv/tb_matrix_inverse_3x3_mod26.sv
`default_nettype none

module tb_matrix_inverse_3x3_mod26;
	timeunit 1ns;
	timeprecision 1ps;

	import mi26_pkg::*;

	// nine residues of one matrix, entry k is row k/3 column k%3
	typedef res_t [8:0] elems_t;

	typedef struct packed {
		elems_t inv;
		logic   singular;
		res_t   det;
	} inverse_t;

	localparam int RandomRequests = 1600;
	localparam int CycleLimit     = 400000;
	localparam int DrainCycles    = 20;

	logic   clk       = 1'b0;
	logic   arst_n    = 1'b0;
	logic   in_valid  = 1'b0;
	logic   out_ready = 1'b0;
	elems_t req_data  = '0;
	logic   in_ready;
	logic   out_valid;
	elems_t rsp_data;
	logic   singular;
	res_t   determinant;

	elems_t   pending_requests[$];
	inverse_t expected_inverses[$];
	int       req_wait   = 0;
	int       rsp_stall  = 0;
	int       req_sent   = 0;
	int       rsp_seen   = 0;
	int       errors     = 0;
	int       cycle_count = 0;

	always #5 clk = ~clk;

	matrix_inverse_3x3_mod26 u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_r0c0    (req_data[0]),
		.in_r0c1    (req_data[1]),
		.in_r0c2    (req_data[2]),
		.in_r1c0    (req_data[3]),
		.in_r1c1    (req_data[4]),
		.in_r1c2    (req_data[5]),
		.in_r2c0    (req_data[6]),
		.in_r2c1    (req_data[7]),
		.in_r2c2    (req_data[8]),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_r0c0   (rsp_data[0]),
		.out_r0c1   (rsp_data[1]),
		.out_r0c2   (rsp_data[2]),
		.out_r1c0   (rsp_data[3]),
		.out_r1c1   (rsp_data[4]),
		.out_r1c2   (rsp_data[5]),
		.out_r2c0   (rsp_data[6]),
		.out_r2c1   (rsp_data[7]),
		.out_r2c2   (rsp_data[8]),
		.singular   (singular),
		.determinant(determinant)
	);

	// a*b - c*d reduced into 0..25, operands already reduced
	function automatic int cofactor26(input int a, input int b, input int c, input int d);
		return ((a * b) % 26 + 26 - (c * d) % 26) % 26;
	endfunction

	// adjugate, determinant and its unit inverse, all with true residues
	function automatic inverse_t predict_inverse(input elems_t a);
		int       m[3][3];
		int       adj[3][3];
		int       det;
		int       unit;
		inverse_t res;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				// 26..31 fold back onto their residue
				m[r][c] = int'(a[r * 3 + c]) % 26;
			end
		end
		adj[0][0] = cofactor26(m[1][1], m[2][2], m[2][1], m[1][2]);
		adj[0][1] = cofactor26(m[0][2], m[2][1], m[0][1], m[2][2]);
		adj[0][2] = cofactor26(m[0][1], m[1][2], m[0][2], m[1][1]);
		adj[1][0] = cofactor26(m[1][2], m[2][0], m[1][0], m[2][2]);
		adj[1][1] = cofactor26(m[0][0], m[2][2], m[0][2], m[2][0]);
		adj[1][2] = cofactor26(m[1][0], m[0][2], m[0][0], m[1][2]);
		adj[2][0] = cofactor26(m[1][0], m[2][1], m[2][0], m[1][1]);
		adj[2][1] = cofactor26(m[2][0], m[0][1], m[0][0], m[2][1]);
		adj[2][2] = cofactor26(m[0][0], m[1][1], m[1][0], m[0][1]);
		det = (m[0][0] * adj[0][0] + m[0][1] * adj[1][0] + m[0][2] * adj[2][0]) % 26;
		unit = 0;
		for (int i = 1; i < 26; i++) begin
			if ((i * det) % 26 == 1) begin
				unit = i;
			end
		end
		// no unit inverse: zero matrix and the flag, determinant still reported
		res.singular = (unit == 0);
		res.det      = res_t'(det);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				res.inv[r * 3 + c] = (unit == 0) ? res_t'(0) : res_t'((adj[r][c] * unit) % 26);
			end
		end
		return res;
	endfunction

	function automatic elems_t pack_rows(input int a0, input int a1, input int a2,
		input int a3, input int a4, input int a5, input int a6, input int a7, input int a8);
		elems_t e;
		e[0] = res_t'(a0);
		e[1] = res_t'(a1);
		e[2] = res_t'(a2);
		e[3] = res_t'(a3);
		e[4] = res_t'(a4);
		e[5] = res_t'(a5);
		e[6] = res_t'(a6);
		e[7] = res_t'(a7);
		e[8] = res_t'(a8);
		return e;
	endfunction

	// random idle wait per item, with every fourth block of 128 items at full rate
	function automatic int draw_wait(input int n);
		if ((n / 128) % 4 == 1) begin
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	// request driver: holds valid and payload until accepted, then waits before the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_data <= '0;
			req_wait <= 0;
		end else begin
			if (in_valid && in_ready) begin
				// the payload sampled here is the one the block takes
				expected_inverses.push_back(predict_inverse(req_data));
				req_sent++;
			end
			if (in_valid && !in_ready) begin
				// stalled request stays on the bus unchanged
			end else if (req_wait != 0) begin
				in_valid <= 1'b0;
				req_wait <= req_wait - 1;
			end else if (pending_requests.size() != 0) begin
				req_data <= pending_requests.pop_front();
				in_valid <= 1'b1;
				req_wait <= draw_wait(req_sent);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor: compares each accepted result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rsp_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_inverses.size() == 0) begin
					$error("unexpected result: determinant %0d singular %0d",
						determinant, singular);
					errors++;
				end else begin
					inverse_t exp_res;
					exp_res = expected_inverses.pop_front();
					for (int k = 0; k < 9; k++) begin
						if (rsp_data[k] !== exp_res.inv[k]) begin
							$error("out_r%0dc%0d expected %0d actual %0d",
								k / 3, k % 3, exp_res.inv[k], rsp_data[k]);
							errors++;
						end
					end
					if (singular !== exp_res.singular) begin
						$error("singular expected %0d actual %0d", exp_res.singular, singular);
						errors++;
					end
					if (determinant !== exp_res.det) begin
						$error("determinant expected %0d actual %0d", exp_res.det, determinant);
						errors++;
					end
				end
				rsp_seen++;
				rsp_stall = draw_wait(rsp_seen);
			end
			// back-pressure also falls while nothing is valid
			if (rsp_stall != 0) begin
				out_ready <= 1'b0;
				rsp_stall = rsp_stall - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("matrix_inverse_3x3_mod26 test failed");
			$finish;
		end
	end

	initial begin
		int mode;
		int v;
		elems_t e;

		// directed: zero and all-ones patterns, units, singular cases, folded inputs
		pending_requests.push_back(pack_rows(0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(pack_rows(31, 31, 31, 31, 31, 31, 31, 31, 31));
		pending_requests.push_back(pack_rows(1, 0, 0, 0, 1, 0, 0, 0, 1));
		pending_requests.push_back(pack_rows(27, 0, 0, 0, 27, 0, 0, 0, 27));
		pending_requests.push_back(pack_rows(25, 0, 0, 0, 25, 0, 0, 0, 25));
		pending_requests.push_back(pack_rows(6, 24, 1, 13, 16, 10, 20, 17, 15));
		pending_requests.push_back(pack_rows(13, 0, 0, 0, 1, 0, 0, 0, 1));
		pending_requests.push_back(pack_rows(2, 0, 0, 0, 1, 0, 0, 0, 1));
		pending_requests.push_back(pack_rows(26, 0, 0, 0, 1, 0, 0, 0, 1));
		pending_requests.push_back(pack_rows(3, 0, 0, 0, 5, 0, 0, 0, 7));
		pending_requests.push_back(pack_rows(0, 1, 0, 0, 0, 1, 1, 0, 0));
		pending_requests.push_back(pack_rows(0, 0, 1, 0, 1, 0, 1, 0, 0));
		pending_requests.push_back(pack_rows(25, 25, 25, 0, 25, 25, 0, 0, 25));
		pending_requests.push_back(pack_rows(25, 25, 25, 25, 25, 25, 25, 25, 25));
		pending_requests.push_back(pack_rows(26, 27, 28, 29, 30, 31, 26, 27, 28));
		pending_requests.push_back(pack_rows(3, 1, 0, 1, 5, 0, 0, 0, 1));
		pending_requests.push_back(pack_rows(21, 21, 21, 21, 21, 21, 21, 21, 21));
		pending_requests.push_back(pack_rows(10, 10, 10, 10, 10, 10, 10, 10, 10));
		pending_requests.push_back(pack_rows(1, 25, 0, 0, 1, 25, 25, 0, 1));
		pending_requests.push_back(pack_rows(0, 25, 24, 25, 0, 23, 24, 23, 0));
		pending_requests.push_back(pack_rows(31, 1, 0, 0, 30, 1, 1, 0, 29));
		pending_requests.push_back(pack_rows(2, 3, 5, 7, 11, 13, 17, 19, 23));

		// random: mostly in-range residues, some folded inputs, some with entries drawn from 0, 1 and 25
		for (int n = 0; n < RandomRequests; n++) begin
			mode = $urandom_range(0, 9);
			for (int k = 0; k < 9; k++) begin
				if (mode < 7) begin
					v = $urandom_range(0, 25);
				end else if (mode < 8) begin
					v = $urandom_range(0, 31);
				end else begin
					case ($urandom_range(0, 2))
						0:       v = 0;
						1:       v = 1;
						default: v = 25;
					endcase
				end
				e[k] = res_t'(v);
			end
			pending_requests.push_back(e);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// every request accepted, then every result back, then a quiet drain
		@(negedge clk);
		while (pending_requests.size() != 0 || in_valid) begin
			@(negedge clk);
		end
		while (expected_inverses.size() != 0) begin
			@(negedge clk);
		end
		repeat (DrainCycles) @(negedge clk);

		if (errors == 0) begin
			$display("matrix_inverse_3x3_mod26 test passed");
		end else begin
			$display("matrix_inverse_3x3_mod26 test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
